@@ hdl/rei_pkg.sv @@
// Shared types, codes and the clamp function for the rotary encoder core.
// No dependencies; every other file imports this package.
package rei_pkg;

    localparam int VALUE_W  = 8;
    localparam int TIME_W   = 32;
    localparam int MS_W     = 16;
    localparam int NEWV_W   = 16;
    localparam int FUNC_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [MS_W-1:0] OK_MS_RESET     = 16'd50;
    localparam logic [MS_W-1:0] CANCEL_MS_RESET = 16'd1000;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PIN         = 3'd0,
        FUNC_TICK        = 3'd1,
        FUNC_READ        = 3'd2,
        FUNC_POLL_OK     = 3'd3,
        FUNC_POLL_CANCEL = 3'd4,
        FUNC_SET         = 3'd5
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_VALUE = 2'd0,
        CFG_MAX_VALUE = 2'd1,
        CFG_OK_MS     = 2'd2,
        CFG_CANCEL_MS = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        BTN_IDLE    = 4'b0001,
        BTN_CLICKED = 4'b0010,
        BTN_OK      = 4'b0100,
        BTN_CANCEL  = 4'b1000
    } btn_state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] min_value;
        logic [VALUE_W-1:0] max_value;
        logic [MS_W-1:0]    ok_ms;
        logic [MS_W-1:0]    cancel_ms;
    } rei_cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] count_value;
        logic               changed;
        logic [2:0]         last_pins;
        btn_state_t         btn_state;
        logic [TIME_W-1:0]  press_start;
        logic [TIME_W-1:0]  now_ms;
    } rei_state_t;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic                     pin_a;
        logic                     pin_b;
        logic                     pin_enter;
        logic signed [NEWV_W-1:0] new_value;
    } rei_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               changed;
        logic               ok_seen;
        logic               cancel_seen;
        logic               button_down;
    } rei_result_t;

    function automatic logic [VALUE_W-1:0] clamp_value(
        input logic signed [NEWV_W-1:0] v,
        input logic [VALUE_W-1:0]       lo,
        input logic [VALUE_W-1:0]       hi
    );
        logic signed [NEWV_W-1:0] t;
        logic signed [NEWV_W-1:0] lo_s;
        logic signed [NEWV_W-1:0] hi_s;
        lo_s = $signed({{(NEWV_W-VALUE_W){1'b0}}, lo});
        hi_s = $signed({{(NEWV_W-VALUE_W){1'b0}}, hi});
        t = v;
        if (t > hi_s) t = hi_s;
        if (t < lo_s) t = lo_s;
        return t[VALUE_W-1:0];
    endfunction

endpackage

@@ hdl/rei_step.sv @@
// Next-state and result logic for one word of the rotary encoder core.
// Depends on rei_pkg.
module rei_step import rei_pkg::*; (
    input  rei_item_t   item,
    input  rei_state_t  st,
    input  rei_cfg_t    cfg,
    output rei_state_t  st_next,
    output rei_result_t res
);

    logic                rise_a;
    logic                enter_diff;
    logic [TIME_W-1:0]   cancel_ext;
    logic [TIME_W-1:0]   ok_ext;
    logic                rel_cancel;
    logic                rel_ok;
    logic [TIME_W-1:0]   threshold;
    logic                timeout;

    assign cancel_ext = {{(TIME_W-MS_W){1'b0}}, cfg.cancel_ms};
    assign ok_ext     = {{(TIME_W-MS_W){1'b0}}, cfg.ok_ms};
    assign rise_a     = !st.last_pins[0] && item.pin_a;
    assign enter_diff = st.last_pins[2] ^ item.pin_enter;
    assign rel_cancel = st.now_ms > (st.press_start + cancel_ext);
    assign rel_ok     = st.now_ms > (st.press_start + ok_ext);
    assign threshold  = (st.now_ms > cancel_ext) ? (st.now_ms - cancel_ext) : '0;
    assign timeout    = st.press_start < threshold;

    always_comb begin
        st_next         = st;
        res.ok_seen     = 1'b0;
        res.cancel_seen = 1'b0;
        case (item.func)
            FUNC_PIN: begin
                if (rise_a) begin
                    if (item.pin_b) begin
                        if (st.count_value > cfg.min_value)
                            st_next.count_value = st.count_value - 1'b1;
                    end else begin
                        if (st.count_value < cfg.max_value)
                            st_next.count_value = st.count_value + 1'b1;
                    end
                    st_next.changed = 1'b1;
                end
                if (enter_diff) begin
                    case (st.btn_state)
                        BTN_IDLE: begin
                            if (!item.pin_enter) begin
                                st_next.btn_state   = BTN_CLICKED;
                                st_next.press_start = st.now_ms;
                            end
                        end
                        BTN_CLICKED: begin
                            if (rel_cancel)
                                st_next.btn_state = BTN_CANCEL;
                            else if (rel_ok)
                                st_next.btn_state = BTN_OK;
                            else
                                st_next.btn_state = BTN_IDLE;
                        end
                        default: ;
                    endcase
                end
                st_next.last_pins = {item.pin_enter, item.pin_b, item.pin_a};
            end
            FUNC_TICK: st_next.now_ms = st.now_ms + 1'b1;
            FUNC_POLL_OK: begin
                if (st.btn_state == BTN_OK) begin
                    st_next.btn_state = BTN_IDLE;
                    res.ok_seen       = 1'b1;
                end
            end
            FUNC_POLL_CANCEL: begin
                if ((st.btn_state == BTN_CLICKED && timeout) ||
                    st.btn_state == BTN_CANCEL) begin
                    st_next.btn_state = BTN_IDLE;
                    res.cancel_seen   = 1'b1;
                end
            end
            FUNC_SET: begin
                st_next.count_value = clamp_value(item.new_value, cfg.min_value,
                                                  cfg.max_value);
            end
            default: ;
        endcase
        res.changed     = st_next.changed;
        res.value       = st_next.count_value;
        res.button_down = !st_next.last_pins[2];
        if (item.func == FUNC_READ) st_next.changed = 1'b0;
    end

endmodule

@@ hdl/rotary_encoder_button_input_core.sv @@
// Top level of the rotary encoder and push button core: input register,
// state, configuration registers and result register. Depends on rei_pkg, rei_step.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | func, pin_a, pin_b, pin_enter, new_value
//  m_      | out       | m_valid / m_ready    | value, changed, ok_seen, cancel_seen, button_down
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word per cycle unless the m_ side stalls; a word taken into the input register
// passes through the step logic and is registered in the result register.
// Synchronous active-low reset clears state and returns the config registers to defaults.
// A stalled m_ side holds the result; the input register keeps taking one more word.
// cfg_ready is always high.
module rotary_encoder_button_input_core import rei_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [FUNC_W-1:0]        s_func,
    input  logic                     s_pin_a,
    input  logic                     s_pin_b,
    input  logic                     s_pin_enter,
    input  logic signed [NEWV_W-1:0] s_new_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [VALUE_W-1:0]       m_value,
    output logic                     m_changed,
    output logic                     m_ok_seen,
    output logic                     m_cancel_seen,
    output logic                     m_button_down,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    rei_item_t   item_reg;
    logic        in_valid_reg;
    rei_state_t  state_reg;
    rei_state_t  state_next;
    rei_state_t  step_state;
    rei_cfg_t    cfg_reg;
    rei_result_t step_res;
    rei_result_t result_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        cfg_write;

    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    rei_step u_step (
        .item    (item_reg),
        .st      (state_reg),
        .cfg     (cfg_reg),
        .st_next (step_state),
        .res     (step_res)
    );

    always_comb begin
        state_next = state_reg;
        if (in_valid_reg && advance) begin
            state_next = step_state;
        end else if (cfg_write &&
                     (cfg_index == CFG_MIN_VALUE || cfg_index == CFG_MAX_VALUE)) begin
            state_next.changed = 1'b0;
            if (cfg_index == CFG_MIN_VALUE)
                state_next.count_value = clamp_value(
                    $signed({{(NEWV_W-VALUE_W){1'b0}}, state_reg.count_value}),
                    cfg_data[VALUE_W-1:0], cfg_reg.max_value);
            else
                state_next.count_value = clamp_value(
                    $signed({{(NEWV_W-VALUE_W){1'b0}}, state_reg.count_value}),
                    cfg_reg.min_value, cfg_data[VALUE_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.count_value <= '0;
            state_reg.changed     <= 1'b0;
            state_reg.last_pins   <= '0;
            state_reg.btn_state   <= BTN_IDLE;
            state_reg.press_start <= '0;
            state_reg.now_ms      <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_value <= '0;
            cfg_reg.max_value <= '0;
            cfg_reg.ok_ms     <= OK_MS_RESET;
            cfg_reg.cancel_ms <= CANCEL_MS_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_MIN_VALUE:    cfg_reg.min_value <= cfg_data[VALUE_W-1:0];
                CFG_MAX_VALUE:    cfg_reg.max_value <= cfg_data[VALUE_W-1:0];
                CFG_OK_MS:        cfg_reg.ok_ms     <= cfg_data[MS_W-1:0];
                CFG_CANCEL_MS:    cfg_reg.cancel_ms <= cfg_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (advance) out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.func      <= s_func;
            item_reg.pin_a     <= s_pin_a;
            item_reg.pin_b     <= s_pin_b;
            item_reg.pin_enter <= s_pin_enter;
            item_reg.new_value <= s_new_value;
        end
        if (in_valid_reg && advance) result_reg <= step_res;
    end

    assign m_valid       = out_valid_reg;
    assign m_value       = result_reg.value;
    assign m_changed     = result_reg.changed;
    assign m_ok_seen     = result_reg.ok_seen;
    assign m_cancel_seen = result_reg.cancel_seen;
    assign m_button_down = result_reg.button_down;

endmodule

@@ hdl/rei_checker.sv @@
// Port-level checks for rotary_encoder_button_input_core, bound to the top level.
// Depends on rei_pkg.
module rei_checker import rei_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [VALUE_W-1:0]       m_value,
    input logic                     m_changed,
    input logic                     m_ok_seen,
    input logic                     m_cancel_seen,
    input logic                     m_button_down
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while result side is ready");

    a_word_reaches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready |=> m_valid)
        else $error("accepted word did not reach the result register");

    a_one_poll_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_ok_seen && m_cancel_seen))
        else $error("ok and cancel reported in one word");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_value) && $stable(m_changed)
            && $stable(m_ok_seen) && $stable(m_cancel_seen) && $stable(m_button_down)))
        else $error("stalled result changed");

endmodule

bind rotary_encoder_button_input_core rei_checker u_rei_checker (.*);
